/* rtl/cdq_pkg.sv */
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types, constants and index helpers for the circular deque.
// ----------------------------------------------------------------------------
package cdq_pkg;

    // Built storage
    localparam int DEPTH  = 1024;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = IDX_W + 1;
    localparam int DATA_W = 32;
    localparam int REQ_W  = 2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 2'd3;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

    // RAM write port
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] data;
    } t_ram_wr;

    // RAM dual read port
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr_a;
        logic [IDX_W-1:0] addr_b;
    } t_ram_rd;

    // Item state while the slot reads are in flight
    typedef struct packed {
        logic              accepted;
        logic              empty;
        logic              full;
        logic [CNT_W-1:0]  count;
        logic              fwd_a;
        logic              fwd_b;
        logic [DATA_W-1:0] wdata;
    } t_s1;

    // Clamp the programmed capacity to 1..DEPTH
    function automatic logic [CNT_W-1:0] eff_cap(input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] res;
        begin
            if (cap == '0) begin
                res = CNT_W'(1);
            end else if (cap > CNT_W'(DEPTH)) begin
                res = CNT_W'(DEPTH);
            end else begin
                res = cap;
            end
            return res;
        end
    endfunction

    // Step forward, wrap at capacity
    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] sum;
        logic [IDX_W-1:0] res;
        begin
            sum = {1'b0, idx} + CNT_W'(1);
            if (sum >= cap) begin
                res = '0;
            end else begin
                res = sum[IDX_W-1:0];
            end
            return res;
        end
    endfunction

    // Step back, wrap to capacity-1 (also for an index beyond capacity)
    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] cap_m1;
        logic [IDX_W-1:0] res;
        begin
            cap_m1 = cap - CNT_W'(1);
            if ((idx == '0) || ({1'b0, idx} > cap)) begin
                res = cap_m1[IDX_W-1:0];
            end else begin
                res = idx - IDX_W'(1);
            end
            return res;
        end
    endfunction

endpackage

/* rtl/cdq_ram.sv */
// ----------------------------------------------------------------------------
// cdq_ram
// Slot storage: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module cdq_ram (
    input  logic                         i_clk,
    input  cdq_pkg::t_ram_wr             i_wr,
    input  cdq_pkg::t_ram_rd             i_rd,
    output logic [cdq_pkg::DATA_W-1:0]   o_rd_data_a,
    output logic [cdq_pkg::DATA_W-1:0]   o_rd_data_b
);

    logic [cdq_pkg::DATA_W-1:0] r_mem [cdq_pkg::DEPTH];
    logic [cdq_pkg::DATA_W-1:0] r_rd_data_a;
    logic [cdq_pkg::DATA_W-1:0] r_rd_data_b;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Read ports, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data_a <= r_mem[i_rd.addr_a];
            r_rd_data_b <= r_mem[i_rd.addr_b];
        end
    end

    assign o_rd_data_a = r_rd_data_a;
    assign o_rd_data_b = r_rd_data_b;

endmodule

/* rtl/circular_deque_unit.sv */
// ----------------------------------------------------------------------------
// circular_deque_unit
// Double-ended ring buffer of signed words with programmable capacity.
// ----------------------------------------------------------------------------
// Takes one request item per cycle while o_in_stall is low (push front,
// push back, pop front, pop back) and returns one result item for each.
// Head, tail and fill count are registers updated at acceptance; the
// words live in a 1024-entry RAM with one write and two read ports. The
// accepting edge writes a pushed word and launches the reads of the new
// front and rear slots; a read that hits the slot written at the same
// edge takes the pushed word by forwarding. The RAM needs no clearing
// pass, so items are taken right after reset. Capacity is written through
// i_cfg_we / i_cfg_wdata; the user must write it while no item is in
// flight, the block does not enforce this; 0 acts as 1, above 1024 as 1024.
module circular_deque_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [cdq_pkg::CNT_W-1:0]         i_cfg_wdata,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [cdq_pkg::REQ_W-1:0]         i_req_type,
    input  logic signed [cdq_pkg::DATA_W-1:0] i_data_in,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_accepted,
    output logic signed [cdq_pkg::DATA_W-1:0] o_front_word,
    output logic signed [cdq_pkg::DATA_W-1:0] o_rear_word,
    output logic                              o_is_empty,
    output logic                              o_is_full,
    output logic [cdq_pkg::CNT_W-1:0]         o_fill_count
);

    // Control state
    logic [cdq_pkg::CNT_W-1:0] r_cap,  n_cap;
    logic [cdq_pkg::IDX_W-1:0] r_head, n_head;
    logic [cdq_pkg::IDX_W-1:0] r_tail, n_tail;
    logic [cdq_pkg::CNT_W-1:0] r_cnt,  n_cnt;
    logic                      r_s1_vld, n_s1_vld;
    logic                      r_out_vld, n_out_vld;
    cdq_pkg::t_s1              r_s1, n_s1;

    // Result registers
    logic                       r_accepted;
    logic [cdq_pkg::DATA_W-1:0] r_front_word;
    logic [cdq_pkg::DATA_W-1:0] r_rear_word;
    logic                       r_is_empty;
    logic                       r_is_full;
    logic [cdq_pkg::CNT_W-1:0]  r_fill_count;

    logic [cdq_pkg::CNT_W-1:0]  w_cap;
    logic                       w_in_acc;
    logic                       w_out_acc;
    logic                       w_s1_adv;
    logic                       w_push;
    logic                       w_ok;
    cdq_pkg::t_ram_wr           w_wr;
    cdq_pkg::t_ram_rd           w_rd;
    logic [cdq_pkg::DATA_W-1:0] w_rd_a;
    logic [cdq_pkg::DATA_W-1:0] w_rd_b;

    // Handshake
    assign w_out_acc  = r_out_vld && !i_out_stall;
    assign w_s1_adv   = r_s1_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_s1_vld && !w_s1_adv;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;

    assign w_cap  = cdq_pkg::eff_cap(r_cap);
    assign w_push = (i_req_type == cdq_pkg::REQ_PUSH_FRONT) ||
                    (i_req_type == cdq_pkg::REQ_PUSH_BACK);

    // Pointer and count update for the offered item
    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_cnt     = r_cnt;
        w_ok      = 1'b0;
        w_wr.en   = 1'b0;
        w_wr.addr = r_head;
        w_wr.data = i_data_in;
        if (w_push) begin
            if (r_cnt < w_cap) begin
                w_ok  = 1'b1;
                n_cnt = r_cnt + cdq_pkg::CNT_W'(1);
                if (r_cnt == '0) begin
                    n_head = '0;
                    n_tail = '0;
                end else if (i_req_type == cdq_pkg::REQ_PUSH_FRONT) begin
                    n_head = cdq_pkg::idx_dec(r_head, w_cap);
                end else begin
                    n_tail = cdq_pkg::idx_inc(r_tail, w_cap);
                end
                w_wr.en   = w_in_acc;
                w_wr.addr = (i_req_type == cdq_pkg::REQ_PUSH_FRONT) ? n_head : n_tail;
            end
        end else if (r_cnt != '0) begin
            w_ok  = 1'b1;
            n_cnt = r_cnt - cdq_pkg::CNT_W'(1);
            if (n_cnt == '0) begin
                n_head = '0;
                n_tail = '0;
            end else if (i_req_type == cdq_pkg::REQ_POP_FRONT) begin
                n_head = cdq_pkg::idx_inc(r_head, w_cap);
            end else begin
                n_tail = cdq_pkg::idx_dec(r_tail, w_cap);
            end
        end
    end

    // Launch reads of the new front and rear slots
    assign w_rd.en     = w_in_acc;
    assign w_rd.addr_a = n_head;
    assign w_rd.addr_b = n_tail;

    cdq_ram u_ram (
        .i_clk       (i_clk),
        .i_wr        (w_wr),
        .i_rd        (w_rd),
        .o_rd_data_a (w_rd_a),
        .o_rd_data_b (w_rd_b)
    );

    // In-flight item, with forwarding of a same-slot write
    always_comb begin
        n_s1.accepted = w_ok;
        n_s1.empty    = (n_cnt == '0);
        n_s1.full     = (n_cnt >= w_cap);
        n_s1.count    = n_cnt;
        n_s1.fwd_a    = w_wr.en && (w_wr.addr == n_head);
        n_s1.fwd_b    = w_wr.en && (w_wr.addr == n_tail);
        n_s1.wdata    = w_wr.data;
    end

    // Valid flags and config
    always_comb begin
        n_cap = i_cfg_we ? i_cfg_wdata : r_cap;
        if (w_in_acc) begin
            n_s1_vld = 1'b1;
        end else if (w_s1_adv) begin
            n_s1_vld = 1'b0;
        end else begin
            n_s1_vld = r_s1_vld;
        end
        if (w_s1_adv) begin
            n_out_vld = 1'b1;
        end else if (w_out_acc) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= cdq_pkg::CAP_RESET;
            r_head    <= '0;
            r_tail    <= '0;
            r_cnt     <= '0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_cap     <= n_cap;
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
            if (w_in_acc) begin
                r_head <= n_head;
                r_tail <= n_tail;
                r_cnt  <= n_cnt;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1 <= n_s1;
        end
        if (w_s1_adv) begin
            r_accepted   <= r_s1.accepted;
            r_is_empty   <= r_s1.empty;
            r_is_full    <= r_s1.full;
            r_fill_count <= r_s1.count;
            r_front_word <= r_s1.empty ? '1 : (r_s1.fwd_a ? r_s1.wdata : w_rd_a);
            r_rear_word  <= r_s1.empty ? '1 : (r_s1.fwd_b ? r_s1.wdata : w_rd_b);
        end
    end

    assign o_accepted   = r_accepted;
    assign o_front_word = r_front_word;
    assign o_rear_word  = r_rear_word;
    assign o_is_empty   = r_is_empty;
    assign o_is_full    = r_is_full;
    assign o_fill_count = r_fill_count;

`ifndef SYNTHESIS
    // Fill count never exceeds the built depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= cdq_pkg::CNT_W'(cdq_pkg::DEPTH))
        else $error("fill count beyond depth");

    // Empty buffer keeps both indices at slot 0
    a_empty_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> ((r_head == '0) && (r_tail == '0)))
        else $error("indices not parked while empty");

    // A push with room grows the count by one
    a_push_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_push && (r_cnt < w_cap)) |=>
            (r_cnt == $past(r_cnt) + cdq_pkg::CNT_W'(1)))
        else $error("push did not count");

    // Empty result shows all-ones words
    a_empty_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && o_is_empty) |->
            ((o_front_word == '1) && (o_rear_word == '1)))
        else $error("empty result words not all ones");
`endif

endmodule

/* tb/sv/circular_deque_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_checker
// Watches the request and result channels of circular_deque_unit, tracks
// the ring contents, pointers, fill level and capacity on its own, and
// compares every result item field by field with the predicted status.
// ----------------------------------------------------------------------------
module circular_deque_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [cdq_pkg::CNT_W-1:0]  i_cfg_wdata,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic [cdq_pkg::REQ_W-1:0]  i_req_type,
    input  logic [cdq_pkg::DATA_W-1:0] i_data_in,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic                       i_accepted,
    input  logic [cdq_pkg::DATA_W-1:0] i_front_word,
    input  logic [cdq_pkg::DATA_W-1:0] i_rear_word,
    input  logic                       i_is_empty,
    input  logic                       i_is_full,
    input  logic [cdq_pkg::CNT_W-1:0]  i_fill_count,
    output int                         o_mismatches,
    output int                         o_pending,
    output int                         o_held_words,
    output int                         o_written_span
);

    // Status carried by one result item
    typedef struct packed {
        logic                       accepted;
        logic [cdq_pkg::DATA_W-1:0] front;
        logic [cdq_pkg::DATA_W-1:0] rear;
        logic                       empty;
        logic                       full;
        logic [cdq_pkg::CNT_W-1:0]  count;
    } t_deque_status;

    logic [cdq_pkg::DATA_W-1:0] ring [cdq_pkg::DEPTH];
    logic                       ring_written [cdq_pkg::DEPTH];
    int                         head_slot;
    int                         tail_slot;
    int                         held_words;
    int                         written_span;
    int                         mismatch_cnt = 0;
    logic [cdq_pkg::CNT_W-1:0]  cap_setting;
    t_deque_status              expected_status_q [$];

    // Apply one request to the ring and return the status it leaves behind
    task automatic advance_deque(input  logic [cdq_pkg::REQ_W-1:0]  req,
                                 input  logic [cdq_pkg::DATA_W-1:0] word,
                                 output t_deque_status              status);
        int   room;
        int   slot;
        logic done;
        // 0 behaves as one slot, anything past the built depth as the depth
        room = (cap_setting == '0) ? 1 :
               ((cap_setting > cdq_pkg::CNT_W'(cdq_pkg::DEPTH)) ? cdq_pkg::DEPTH :
                int'(cap_setting));
        done = 1'b0;
        if (req == cdq_pkg::REQ_PUSH_FRONT || req == cdq_pkg::REQ_PUSH_BACK) begin
            if (held_words < room) begin
                done = 1'b1;
                if (held_words == 0) begin
                    // first word always lands in slot 0
                    head_slot = 0;
                    tail_slot = 0;
                end else if (req == cdq_pkg::REQ_PUSH_FRONT) begin
                    // an index left beyond a shrunk capacity also wraps to the top
                    head_slot = (head_slot == 0 || head_slot > room) ? room - 1 : head_slot - 1;
                end else begin
                    tail_slot = (tail_slot + 1 >= room) ? 0 : tail_slot + 1;
                end
                slot = (req == cdq_pkg::REQ_PUSH_FRONT) ? head_slot : tail_slot;
                ring[slot]         = word;
                ring_written[slot] = 1'b1;
                while (written_span < cdq_pkg::DEPTH && ring_written[written_span])
                    written_span++;
                held_words++;
            end
        end else if (held_words > 0) begin
            done = 1'b1;
            held_words--;
            if (held_words == 0) begin
                head_slot = 0;
                tail_slot = 0;
            end else if (req == cdq_pkg::REQ_POP_FRONT) begin
                head_slot = (head_slot + 1 >= room) ? 0 : head_slot + 1;
            end else begin
                tail_slot = (tail_slot == 0 || tail_slot > room) ? room - 1 : tail_slot - 1;
            end
        end
        status.accepted = done;
        status.front    = (held_words == 0) ? '1 : ring[head_slot];
        status.rear     = (held_words == 0) ? '1 : ring[tail_slot];
        status.empty    = (held_words == 0);
        status.full     = (held_words >= room);
        status.count    = cdq_pkg::CNT_W'(held_words);
    endtask

    // Predict on each accepted request, compare on each accepted result
    always @(posedge i_clk) begin : monitor
        t_deque_status want;
        t_deque_status got;
        if (!i_rst_n) begin
            head_slot    = 0;
            tail_slot    = 0;
            held_words   = 0;
            written_span = 0;
            cap_setting  = cdq_pkg::CAP_RESET;
            for (int i = 0; i < cdq_pkg::DEPTH; i++)
                ring_written[i] = 1'b0;
            expected_status_q.delete();
        end else begin
            if (i_cfg_we)
                cap_setting = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) begin
                advance_deque(i_req_type, i_data_in, want);
                expected_status_q.push_back(want);
            end
            if (i_out_valid && !i_out_stall) begin
                got.accepted = i_accepted;
                got.front    = i_front_word;
                got.rear     = i_rear_word;
                got.empty    = i_is_empty;
                got.full     = i_is_full;
                got.count    = i_fill_count;
                if (expected_status_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: result item with no request outstanding", $time);
                end else begin
                    want = expected_status_q.pop_front();
                    if (got.accepted !== want.accepted || got.front !== want.front ||
                        got.rear !== want.rear || got.empty !== want.empty ||
                        got.full !== want.full || got.count !== want.count) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("%0t: result item mismatch", $time);
                            $display({"  expected acc=%0b front=%h rear=%h",
                                      " empty=%0b full=%0b count=%0d"},
                                     want.accepted, want.front, want.rear, want.empty,
                                     want.full, want.count);
                            $display({"  actual   acc=%0b front=%h rear=%h",
                                      " empty=%0b full=%0b count=%0d"},
                                     got.accepted, got.front, got.rear, got.empty,
                                     got.full, got.count);
                        end
                    end
                end
            end
        end
        o_mismatches   <= mismatch_cnt;
        o_pending      <= expected_status_q.size();
        o_held_words   <= held_words;
        o_written_span <= written_span;
    end

endmodule

/* tb/sv/tb_circular_deque_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_deque_unit
// Drives request items into circular_deque_unit with random gaps and output
// stalls, moves the capacity through small, clamped and full-depth values,
// and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_circular_deque_unit;

    localparam int HALF_PERIOD = 6;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_COUNT = 16;
    localparam int PHASE_ITEMS = 106;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [cdq_pkg::CNT_W-1:0]  cfg_wdata;
    logic                       in_valid;
    logic                       in_stall;
    logic [cdq_pkg::REQ_W-1:0]  req_type;
    logic [cdq_pkg::DATA_W-1:0] data_in;
    logic                       out_valid;
    logic                       out_stall;
    logic                       accepted;
    logic [cdq_pkg::DATA_W-1:0] front_word;
    logic [cdq_pkg::DATA_W-1:0] rear_word;
    logic                       is_empty;
    logic                       is_full;
    logic [cdq_pkg::CNT_W-1:0]  fill_count;

    logic                       idle_on      = 1'b1;
    logic                       hold_trigger = 1'b0;
    int                         quiet_cycles = 0;
    logic [cdq_pkg::CNT_W-1:0]  phase_caps [PHASE_COUNT];
    int                         mismatches;
    int                         pending;
    int                         held_words;
    int                         written_span;

    circular_deque_unit i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_req_type   (req_type),
        .i_data_in    (data_in),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_accepted   (accepted),
        .o_front_word (front_word),
        .o_rear_word  (rear_word),
        .o_is_empty   (is_empty),
        .o_is_full    (is_full),
        .o_fill_count (fill_count)
    );

    circular_deque_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_req_type     (req_type),
        .i_data_in      (data_in),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_accepted     (accepted),
        .i_front_word   (front_word),
        .i_rear_word    (rear_word),
        .i_is_empty     (is_empty),
        .i_is_full      (is_full),
        .i_fill_count   (fill_count),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_held_words   (held_words),
        .o_written_span (written_span)
    );

    // 12 ns clock
    initial begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // Random word, biased toward the signed extremes, zero and all ones
    function automatic logic [cdq_pkg::DATA_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return 32'h7fff_ffff;
        if (r < 12)
            return 32'h8000_0000;
        if (r < 16)
            return 32'h0000_0000;
        if (r < 20)
            return 32'hffff_ffff;
        return $urandom;
    endfunction

    // Offer one item after a random gap and hold it until taken
    task automatic send_req(input logic [cdq_pkg::REQ_W-1:0]  req,
                            input logic [cdq_pkg::DATA_W-1:0] word);
        int gap;
        int r;
        gap = 0;
        if (idle_on) begin
            r = $urandom_range(0, 99);
            if (r < 60)
                gap = 0;
            else if (r < 90)
                gap = $urandom_range(1, 3);
            else if (r < 98)
                gap = $urandom_range(4, 12);
            else
                gap = $urandom_range(20, 40);
        end
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        req_type <= req;
        data_in  <= word;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stop offering and wait until every result item has come back
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Capacity write while idle. Growing past the slots known to be written
    // while words are held could park an index on a stale-free slot, so the
    // buffer is emptied first in that case.
    task automatic set_capacity(input logic [cdq_pkg::CNT_W-1:0] value);
        int room;
        int n;
        room = (value == '0) ? 1 :
               ((value > cdq_pkg::CNT_W'(cdq_pkg::DEPTH)) ? cdq_pkg::DEPTH : int'(value));
        settle();
        if (held_words != 0 && room > written_span) begin
            n = held_words;
            repeat (n)
                send_req($urandom_range(0, 1) ? cdq_pkg::REQ_POP_FRONT : cdq_pkg::REQ_POP_BACK,
                         pick_word());
            settle();
        end
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Result side: random stall bursts, plus one long hold-off on request
    initial begin : receiver
        int burst_left;
        int hold_left;
        int r;
        burst_left = 0;
        hold_left  = 0;
        out_stall  = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_trigger) begin
                hold_trigger = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (!idle_on) begin
                out_stall <= 1'b0;
            end else if (burst_left > 0) begin
                burst_left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    out_stall  <= 1'b0;
                    burst_left = $urandom_range(0, 7);
                end else if (r < 95) begin
                    out_stall  <= 1'b1;
                    burst_left = $urandom_range(0, 3);
                end else begin
                    out_stall  <= 1'b1;
                    burst_left = $urandom_range(14, 39);
                end
            end
        end
    end

    // Watchdog: too long without any item moving on either channel
    always @(posedge clk) begin
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus and verdict
    initial begin : stimulus
        int                        push_pct;
        logic [cdq_pkg::REQ_W-1:0] req;
        phase_caps = '{5, 3, 1, 0, 2, 1024, 17, 2047, 40, 1025, 8, 64, 2, 200, 11, 1024};
        in_valid  = 1'b0;
        req_type  = cdq_pkg::REQ_PUSH_FRONT;
        data_in   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        rst_n     = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Pops on empty, extreme words pushed at both ends, drain to empty
        send_req(cdq_pkg::REQ_POP_FRONT, 32'h0000_0000);
        send_req(cdq_pkg::REQ_POP_BACK, 32'hffff_ffff);
        send_req(cdq_pkg::REQ_PUSH_FRONT, 32'h7fff_ffff);
        send_req(cdq_pkg::REQ_PUSH_BACK, 32'h8000_0000);
        send_req(cdq_pkg::REQ_PUSH_FRONT, 32'h0000_0000);
        send_req(cdq_pkg::REQ_PUSH_BACK, 32'hffff_ffff);
        send_req(cdq_pkg::REQ_POP_FRONT, 32'h0000_0000);
        send_req(cdq_pkg::REQ_POP_BACK, 32'h0000_0000);
        send_req(cdq_pkg::REQ_POP_FRONT, 32'h0000_0000);
        send_req(cdq_pkg::REQ_POP_BACK, 32'h0000_0000);
        send_req(cdq_pkg::REQ_PUSH_BACK, 32'h5555_5555);
        send_req(cdq_pkg::REQ_POP_FRONT, 32'haaaa_aaaa);

        // Small capacity: fill, refused pushes, then shrink with words held
        set_capacity(8);
        for (int k = 0; k < 8; k++)
            send_req(k[0] ? cdq_pkg::REQ_PUSH_FRONT : cdq_pkg::REQ_PUSH_BACK, pick_word());
        send_req(cdq_pkg::REQ_PUSH_FRONT, pick_word());
        send_req(cdq_pkg::REQ_PUSH_BACK, pick_word());
        set_capacity(3);
        send_req(cdq_pkg::REQ_PUSH_BACK, pick_word());
        send_req(cdq_pkg::REQ_POP_FRONT, pick_word());
        send_req(cdq_pkg::REQ_POP_BACK, pick_word());
        send_req(cdq_pkg::REQ_PUSH_FRONT, pick_word());

        // Receiver holds off while pushes keep coming, so the input backs up
        set_capacity(64);
        hold_trigger = 1'b1;
        repeat (70)
            send_req($urandom_range(0, 1) ? cdq_pkg::REQ_PUSH_FRONT : cdq_pkg::REQ_PUSH_BACK,
                     pick_word());

        // Random phases: push-heavy half then pop-heavy half per capacity
        for (int p = 0; p < PHASE_COUNT; p++) begin
            idle_on = (p % 4 != 3);
            set_capacity(phase_caps[p]);
            push_pct = $urandom_range(55, 85);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k == PHASE_ITEMS / 2)
                    push_pct = 100 - push_pct;
                if ($urandom_range(0, 99) < push_pct)
                    req = $urandom_range(0, 1) ? cdq_pkg::REQ_PUSH_FRONT :
                                                 cdq_pkg::REQ_PUSH_BACK;
                else
                    req = $urandom_range(0, 1) ? cdq_pkg::REQ_POP_FRONT :
                                                 cdq_pkg::REQ_POP_BACK;
                send_req(req, pick_word());
            end
        end

        settle();
        repeat (10) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
